// ===== rtl/peak_aligned_frame_extractor_core_defines.svh =====
// Assertion helpers for the frame extractor.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef PEAK_ALIGNED_FRAME_EXTRACTOR_CORE_DEFINES_SVH
`define PEAK_ALIGNED_FRAME_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication
`define PAFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PAFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pafe_pkg.sv =====
`default_nettype none

package pafe_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ALIGN_MARGIN = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
  typedef logic [7:0]                 win_cfg_t;
  typedef logic [30:0]                thr_t;

  // Register indexes
  localparam cfg_idx_t CFG_PEAK_WINDOW    = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_PEAK_THRESHOLD = cfg_idx_t'(1);

  localparam win_cfg_t PW_RESET  = 8'd64;
  localparam thr_t     THR_RESET = 31'd20000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SRCH,
    ST_SDRAIN,
    ST_DECIDE,
    ST_FRD,
    ST_FLOAD,
    ST_FPEAK,
    ST_FOUT,
    ST_FIN
  } pafe_state_t;

endpackage

`default_nettype wire

// ===== rtl/pafe_ifs.sv =====
`default_nettype none

// Input sample channel
interface pafe_in_if;
  logic             valid;
  logic             ready;
  pafe_pkg::sample_t raw_sample;
  pafe_pkg::sample_t filtered_sample;

  modport source (output valid, output raw_sample, output filtered_sample, input ready);
  modport sink   (input valid, input raw_sample, input filtered_sample, output ready);
endinterface

// Frame sample channel
interface pafe_out_if;
  logic              valid;
  logic              ready;
  pafe_pkg::sample_t frame_sample;
  pafe_pkg::pos_t    sample_position;
  logic              frame_last;
  logic              peak_valid;
  pafe_pkg::pos_t    peak_position;

  modport source (output valid, output frame_sample, output sample_position,
                  output frame_last, output peak_valid, output peak_position,
                  input ready);
  modport sink   (input valid, input frame_sample, input sample_position,
                  input frame_last, input peak_valid, input peak_position,
                  output ready);
endinterface

// Register write channel
interface pafe_cfg_if;
  logic                valid;
  logic                ready;
  pafe_pkg::cfg_idx_t  idx;
  pafe_pkg::cfg_data_t data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/peak_aligned_frame_extractor_core.sv =====
`default_nettype none
`include "peak_aligned_frame_extractor_core_defines.svh"

// Peak-aligned frame extractor. Each input transaction appends one raw and one
// filtered sample to two circular stores of STORE_DEPTH entries (the oldest pair is
// dropped when full). Once more samples are stored than the peak window (register
// peak_window, 0 acts as 1, capped at WINDOW_MAX), the newest window of raw samples
// is scanned for its first maximum; if that maximum lies at least FRAME_LEN-5
// samples from the oldest, FRAME_LEN filtered samples are sent from the oldest on
// (positions beyond the stored samples read as zero), the last one carrying the
// frame's first-maximum position and a flag set when that maximum exceeds
// peak_threshold, and the samples before the alignment peak are discarded. Items
// are taken one at a time: a new sample pair is not accepted until its storing,
// the window scan and any frame are done, and the single store read port and one
// shared comparator walk every sample in turn. Registers may be written at any
// time the block is idle; the write channel is always ready.
module peak_aligned_frame_extractor_core #(
  parameter int FRAME_LEN   = 64,
  parameter int WINDOW_MAX  = 128,
  parameter int STORE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  pafe_in_if.sink        in_ch,
  pafe_out_if.source     out_ch,
  pafe_cfg_if.sink       cfg_ch
);
  import pafe_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW:0]   DEPTH_X   = (CW+1)'(STORE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(STORE_DEPTH);
  localparam logic [CW-1:0] FULL_M1   = CW'(STORE_DEPTH - 1);
  localparam logic [9:0]    WMAX_L    = 10'(WINDOW_MAX);
  localparam logic [CW-1:0] ALIGN_MIN = CW'(FRAME_LEN - ALIGN_MARGIN);
  localparam pos_t          LAST_POS  = POS_W'(FRAME_LEN - 1);

  // Circular slot of a sample given its age from the base pointer
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] age);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(age);
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  pafe_state_t state_r, state_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  win_cfg_t      pw_r;
  thr_t          thr_r;

  sample_t       cap_raw_r, cap_filt_r;
  logic [CW-1:0] i_r, i_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pidx_r, pidx_nxt;
  logic          first_r, first_nxt;
  sample_t       best_r, best_nxt;
  logic [CW-1:0] bidx_r, bidx_nxt;
  logic [CW-1:0] off_r, off_nxt;
  pos_t          k_r, k_nxt;

  logic    ov_r, ov_nxt;
  sample_t od_r, od_nxt;
  pos_t    opos_r, opos_nxt;
  logic    olast_r, olast_nxt;
  logic    opv_r, opv_nxt;
  pos_t    opp_r, opp_nxt;

  // Sample stores
  sample_t       raw_mem  [STORE_DEPTH];
  sample_t       filt_mem [STORE_DEPTH];
  sample_t       raw_q, filt_q;
  logic          mem_we;
  logic [AW-1:0] wr_addr, rd_addr;

  // Shared comparator
  sample_t cmp_a, cmp_b;
  logic    cmp_gt;

  logic          in_acc, out_acc;
  logic          full;
  logic [AW-1:0] oldest_d;
  logic [CW-1:0] fill_d, fill_new;
  logic [9:0]    pw_x, win10;
  logic [CW-1:0] win_w;
  sample_t       fval;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;

  assign out_ch.valid           = ov_r;
  assign out_ch.frame_sample    = od_r;
  assign out_ch.sample_position = opos_r;
  assign out_ch.frame_last      = olast_r;
  assign out_ch.peak_valid      = opv_r;
  assign out_ch.peak_position   = opp_r;

  assign cmp_gt = cmp_a > cmp_b;

  // Store full: drop the oldest pair first
  assign full     = (fill_r == DEPTH_C);
  assign oldest_d = full ? slot_of(oldest_r, CW'(1)) : oldest_r;
  assign fill_d   = full ? FULL_M1 : fill_r;
  assign fill_new = fill_d + 1'b1;

  // Effective window: zero acts as one, capped at WINDOW_MAX
  always_comb begin
    pw_x  = {2'b00, pw_r};
    win10 = (pw_x > WMAX_L) ? WMAX_L : pw_x;
    if (win10 == 10'd0) begin
      win10 = 10'd1;
    end
    win_w = CW'(win10);
  end

  // Frame value, zero past the stored samples
  assign fval = (CW'(k_r) < fill_r) ? filt_q : '0;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    fill_nxt   = fill_r;
    i_nxt      = i_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    first_nxt  = first_r;
    best_nxt   = best_r;
    bidx_nxt   = bidx_r;
    off_nxt    = off_r;
    k_nxt      = k_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    opos_nxt   = opos_r;
    olast_nxt  = olast_r;
    opv_nxt    = opv_r;
    opp_nxt    = opp_r;
    mem_we     = 1'b0;
    wr_addr    = slot_of(oldest_d, fill_d);
    rd_addr    = slot_of(oldest_r, i_r);
    cmp_a      = raw_q;
    cmp_b      = best_r;

    // Window scan: fold in the raw sample read last cycle
    if (pend_r) begin
      if (first_r || cmp_gt) begin
        best_nxt  = raw_q;
        bidx_nxt  = pidx_r;
        first_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        mem_we     = 1'b1;
        oldest_nxt = oldest_d;
        fill_nxt   = fill_new;
        if (fill_new > win_w) begin
          i_nxt     = fill_new - win_w;
          first_nxt = 1'b1;
          state_nxt = ST_SRCH;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SRCH: begin
        pend_nxt = 1'b1;
        pidx_nxt = i_r;
        i_nxt    = i_r + 1'b1;
        if (i_r + 1'b1 == fill_r) begin
          state_nxt = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (bidx_r >= ALIGN_MIN) begin
          off_nxt   = bidx_r;
          k_nxt     = '0;
          first_nxt = 1'b1;
          state_nxt = ST_FRD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FRD: begin
        rd_addr   = slot_of(oldest_r, CW'(k_r));
        state_nxt = ST_FLOAD;
      end
      ST_FLOAD: begin
        // Track the frame's first maximum while loading the output register
        cmp_a = fval;
        if (first_r || cmp_gt) begin
          best_nxt  = fval;
          bidx_nxt  = CW'(k_r);
          first_nxt = 1'b0;
        end
        od_nxt    = fval;
        opos_nxt  = k_r;
        olast_nxt = (k_r == LAST_POS);
        opv_nxt   = 1'b0;
        opp_nxt   = '0;
        if (k_r == LAST_POS) begin
          state_nxt = ST_FPEAK;
        end else begin
          ov_nxt    = 1'b1;
          state_nxt = ST_FOUT;
        end
      end
      ST_FPEAK: begin
        cmp_a     = best_r;
        cmp_b     = sample_t'({1'b0, thr_r});
        opv_nxt   = cmp_gt;
        opp_nxt   = bidx_r[POS_W-1:0];
        ov_nxt    = 1'b1;
        state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        if (out_ch.ready) begin
          ov_nxt = 1'b0;
          if (olast_r) begin
            state_nxt = ST_FIN;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_FRD;
          end
        end
      end
      ST_FIN: begin
        oldest_nxt = slot_of(oldest_r, off_r);
        fill_nxt   = fill_r - off_r;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      oldest_r <= '0;
      fill_r   <= '0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
      pw_r     <= PW_RESET;
      thr_r    <= THR_RESET;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      fill_r   <= fill_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.idx)
          CFG_PEAK_WINDOW:    pw_r  <= cfg_ch.data[7:0];
          CFG_PEAK_THRESHOLD: thr_r <= cfg_ch.data[30:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cap_raw_r  <= in_ch.raw_sample;
      cap_filt_r <= in_ch.filtered_sample;
    end
    i_r     <= i_nxt;
    pidx_r  <= pidx_nxt;
    first_r <= first_nxt;
    best_r  <= best_nxt;
    bidx_r  <= bidx_nxt;
    off_r   <= off_nxt;
    k_r     <= k_nxt;
    od_r    <= od_nxt;
    opos_r  <= opos_nxt;
    olast_r <= olast_nxt;
    opv_r   <= opv_nxt;
    opp_r   <= opp_nxt;
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      raw_mem[wr_addr]  <= cap_raw_r;
      filt_mem[wr_addr] <= cap_filt_r;
    end
    raw_q  <= raw_mem[rd_addr];
    filt_q <= filt_mem[rd_addr];
  end

  `PAFE_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= DEPTH_C, "fill count above store depth")
  `PAFE_ASSERT_NOW(a_scan_in_range, state_r == ST_SRCH, i_r < fill_r,
                   "scan index past stored samples")
  `PAFE_ASSERT_NOW(a_discard_range, state_r == ST_FIN,
                   (off_r >= ALIGN_MIN) && (off_r < fill_r), "discard count out of range")
  `PAFE_ASSERT_NOW(a_no_accept_busy_out, in_ch.ready, !ov_r,
                   "input ready while a frame sample is pending")
  `PAFE_ASSERT_NEXT(a_last_then_discard, out_acc && olast_r, state_r == ST_FIN,
                    "frame end not followed by discard")

endmodule

`default_nettype wire

// ===== test/tb_peak_aligned_frame_extractor_core.sv =====
`default_nettype none

module tb_peak_aligned_frame_extractor_core;
  import pafe_pkg::*;

  localparam int FRAME_LEN   = 64;
  localparam int WINDOW_MAX  = 128;
  localparam int STORE_DEPTH = 256;

  // Worst single item: store, full window scan and frame walk
  localparam int ITEM_LATENCY = 2 + (WINDOW_MAX + 2) + 4 * FRAME_LEN + 8;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;

  // Indexes past the register list; writes there must be dropped
  localparam cfg_idx_t CFG_SPARE_2 = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_SPARE_3 = cfg_idx_t'(3);

  // Field extremes, walking patterns and repeated maxima
  localparam logic [31:0] EDGE_RAW [16] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h7FFF_FFFE,
    32'h8000_0001, 32'h0000_0064, 32'h0000_0064, 32'h0000_0064,
    32'h0000_0000, 32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h0000_0003};
  localparam logic [31:0] EDGE_FILT [16] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_4E20, 32'h0000_4E21,
    32'h7FFF_FFFF, 32'h0000_4E1F, 32'h8000_0001, 32'h0000_0001,
    32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0000_4E21, 32'h0000_0000};

  typedef struct packed {
    sample_t frame_sample;
    pos_t    sample_position;
    logic    frame_last;
    logic    peak_valid;
    pos_t    peak_position;
  } frame_word_t;

  typedef enum int {
    FILT_WIDE,
    FILT_NEAR_THRESHOLD,
    FILT_NEGATIVE,
    FILT_FEW_LEVELS,
    FILT_EXTREMES
  } filt_style_t;

  // Mirrors the sample stores and predicts every frame word
  class frame_word_scoreboard;
    sample_t     raw_hist [STORE_DEPTH];
    sample_t     filt_hist[STORE_DEPTH];
    int unsigned head;
    int unsigned fill;
    win_cfg_t    window_reg;
    thr_t        threshold_reg;
    frame_word_t expected_words[$];
    int unsigned errors;
    int unsigned reported;
    int unsigned samples_seen;
    int unsigned frames_predicted;
    int unsigned words_checked;
    int unsigned reg_writes;

    function new();
      head          = 0;
      fill          = 0;
      window_reg    = PW_RESET;
      threshold_reg = THR_RESET;
    endfunction

    function int unsigned slot(int unsigned age);
      return (head + age) % STORE_DEPTH;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void flag_error(string msg);
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endfunction

    function void write_register(cfg_idx_t idx, cfg_data_t data);
      reg_writes++;
      case (idx)
        CFG_PEAK_WINDOW:    window_reg = data[7:0];
        CFG_PEAK_THRESHOLD: threshold_reg = data[30:0];
        default: ;
      endcase
    endfunction

    // One accepted sample pair: store it, search the window, maybe emit a frame
    function void note_sample(sample_t raw, sample_t filt);
      int unsigned win, start_age, best_age, age, k, pk_idx;
      sample_t     best, pk_val, thr_s;
      sample_t     frame_buf[FRAME_LEN];
      frame_word_t w;
      samples_seen++;
      if (fill >= STORE_DEPTH) begin
        head = (head + 1) % STORE_DEPTH;
        fill = STORE_DEPTH - 1;
      end
      raw_hist[slot(fill)]  = raw;
      filt_hist[slot(fill)] = filt;
      fill++;

      win = (window_reg == 0) ? 1 : window_reg;
      if (win > WINDOW_MAX) win = WINDOW_MAX;
      if (fill <= win) return;

      // first maximum of the newest window decides the alignment
      start_age = fill - win;
      best_age  = start_age;
      best      = raw_hist[slot(start_age)];
      for (age = start_age + 1; age < fill; age++) begin
        if (raw_hist[slot(age)] > best) begin
          best     = raw_hist[slot(age)];
          best_age = age;
        end
      end
      if (best_age < FRAME_LEN - ALIGN_MARGIN) return;

      // frame from the oldest sample; unfilled positions read as zero
      for (k = 0; k < FRAME_LEN; k++)
        frame_buf[k] = (k < fill) ? filt_hist[slot(k)] : '0;
      pk_idx = 0;
      pk_val = frame_buf[0];
      for (k = 1; k < FRAME_LEN; k++) begin
        if (frame_buf[k] > pk_val) begin
          pk_val = frame_buf[k];
          pk_idx = k;
        end
      end
      thr_s = sample_t'({1'b0, threshold_reg});

      for (k = 0; k < FRAME_LEN; k++) begin
        w.frame_sample    = frame_buf[k];
        w.sample_position = pos_t'(k);
        w.frame_last      = (k == FRAME_LEN - 1);
        w.peak_valid      = w.frame_last && (pk_val > thr_s);
        w.peak_position   = w.frame_last ? pos_t'(pk_idx) : '0;
        expected_words.push_back(w);
      end
      frames_predicted++;

      head = (head + best_age) % STORE_DEPTH;
      fill = fill - best_age;
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      if (expected_words.size() == 0) begin
        flag_error($sformatf("unexpected word sample=%0d pos=%0d last=%0b",
                             got.frame_sample, got.sample_position, got.frame_last));
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got.frame_sample !== want.frame_sample ||
          got.sample_position !== want.sample_position ||
          got.frame_last !== want.frame_last ||
          got.peak_valid !== want.peak_valid ||
          got.peak_position !== want.peak_position)
        flag_error($sformatf({"word %0d: expected sample=%0d pos=%0d last=%0b pv=%0b ",
                              "pp=%0d, got sample=%0d pos=%0d last=%0b pv=%0b pp=%0d"},
                             words_checked, want.frame_sample, want.sample_position,
                             want.frame_last, want.peak_valid, want.peak_position,
                             got.frame_sample, got.sample_position, got.frame_last,
                             got.peak_valid, got.peak_position));
    endfunction

    function void check_drained();
      if (expected_words.size() != 0)
        flag_error($sformatf("%0d frame words never arrived", expected_words.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pafe_in_if  in_if();
  pafe_out_if out_if();
  pafe_cfg_if cfg_if();

  peak_aligned_frame_extractor_core #(
    .FRAME_LEN  (FRAME_LEN),
    .WINDOW_MAX (WINDOW_MAX),
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  frame_word_scoreboard sb;

  bit          steady;       // no idling on either side
  bit          hold_armed;   // sink stalls long once a frame is pending
  int unsigned holds_done;
  int unsigned spike_left = 20;
  filt_style_t filt_style = FILT_WIDE;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Spike train on raw (gives clean alignment peaks) with noise and ties mixed in
  function automatic void next_item(output sample_t raw, output sample_t filt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (spike_left == 0) begin
      raw        = ($urandom_range(0, 3) == 0) ? sample_t'(32'h7FFF_FFFF)
                 : sample_t'($urandom_range(32'h4000_0000, 32'h7FFF_FFFE));
      spike_left = $urandom_range(30, 90);
      filt_style = filt_style_t'($urandom_range(FILT_WIDE, FILT_EXTREMES));
    end else begin
      spike_left--;
      if (r < 72)      raw = sample_t'($urandom_range(0, 2000)) - 1000;
      else if (r < 82) raw = sample_t'($urandom);
      else if (r < 94) raw = sample_t'(32'd500);
      else             raw = r[0] ? sample_t'(32'h8000_0000) : sample_t'(32'h7FFF_FFFF);
    end

    case (filt_style)
      FILT_WIDE:           filt = sample_t'($urandom);
      FILT_NEAR_THRESHOLD: filt = sample_t'({1'b0, sb.threshold_reg})
                                  + sample_t'($urandom_range(0, 6)) - 3;
      FILT_NEGATIVE:       filt = sample_t'($urandom | 32'h8000_0000);
      FILT_FEW_LEVELS:     filt = sample_t'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0:       filt = sample_t'(32'h7FFF_FFFF);
          1:       filt = sample_t'(32'h8000_0000);
          2:       filt = '0;
          default: filt = sample_t'(32'hFFFF_FFFF);
        endcase
      end
    endcase
  endfunction

  // Offer one sample pair; returns at the falling edge after the transaction
  task automatic send_sample(sample_t raw, sample_t filt, int unsigned gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.raw_sample      <= raw;
    in_if.filtered_sample <= filt;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(raw, filt);
    @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering, let all frames drain and the last scan finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (ITEM_LATENCY) @(negedge clk);
  endtask

  // Register settings per phase; upper junk bits check the field masking
  task automatic program_phase(int unsigned p);
    case (p)
      1: begin
        write_register(CFG_SPARE_2, cfg_data_t'($urandom));
        write_register(CFG_SPARE_3, cfg_data_t'($urandom));
        write_register(CFG_PEAK_WINDOW, cfg_data_t'({$urandom, 8'h00}));
        write_register(CFG_PEAK_THRESHOLD,
                       cfg_data_t'(32'h7FFF_FFFF | ($urandom & 32'h8000_0000)));
      end
      2: begin
        write_register(CFG_PEAK_WINDOW, cfg_data_t'({$urandom, 8'hFF}));
        write_register(CFG_PEAK_THRESHOLD, cfg_data_t'($urandom & 32'h8000_0000));
      end
      3: begin
        write_register(CFG_PEAK_WINDOW, cfg_data_t'(32'd1));
        write_register(CFG_PEAK_THRESHOLD, cfg_data_t'(THR_RESET));
      end
      default: begin
        write_register(CFG_PEAK_WINDOW, ($urandom_range(0, 1) == 0)
                       ? cfg_data_t'(WINDOW_MAX) : cfg_data_t'($urandom_range(2, 254)));
        write_register(CFG_PEAK_THRESHOLD, ($urandom_range(0, 1) == 0)
                       ? cfg_data_t'($urandom) : cfg_data_t'($urandom_range(0, 70000)));
      end
    endcase
  endtask

  // Sink pacing, including the one long hold while a frame is waiting
  initial begin : sink_pacing
    int unsigned gap;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && sb != null && sb.pending() > 0) begin
        hold_armed = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Frame word monitor
  always @(posedge clk) begin : frame_monitor
    frame_word_t seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen.frame_sample    = out_if.frame_sample;
      seen.sample_position = out_if.sample_position;
      seen.frame_last      = out_if.frame_last;
      seen.peak_valid      = out_if.peak_valid;
      seen.peak_position   = out_if.peak_position;
      sb.check_word(seen);
    end
  end

  // Watchdog: too long without any transaction on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned p, i, phase_items, frames_at_start;
    bit          paused;
    sample_t     raw, filt;
    sb = new();
    in_if.valid           <= 1'b0;
    in_if.raw_sample      <= '0;
    in_if.filtered_sample <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.idx            <= CFG_PEAK_WINDOW;
    cfg_if.data           <= '0;
    rst_n                 <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed extremes under the reset register values
    for (i = 0; i < 16; i++)
      send_sample(sample_t'(EDGE_RAW[i]), sample_t'(EDGE_FILT[i]), 0);

    // each phase runs at least 12 items and until it has produced a frame, up to 250 items
    paused = 1'b0;
    for (p = 0; p < 5; p++) begin
      if (p > 0) begin
        settle();
        program_phase(p);
      end
      steady = (p == 3);
      if (p == 1) hold_armed = 1'b1;
      frames_at_start = sb.frames_predicted;
      phase_items     = 0;
      while (phase_items < 12 ||
             (sb.frames_predicted == frames_at_start && phase_items < 250)) begin
        next_item(raw, filt);
        send_sample(raw, filt, steady ? 0 : pick_gap());
        phase_items++;
        // once: hold the source until the pending frame is fully out
        if (p == 2 && !paused && sb.pending() > 0) begin
          paused = 1'b1;
          in_if.valid <= 1'b0;
          while (sb.pending() != 0) @(negedge clk);
        end
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (ITEM_LATENCY) @(negedge clk);
    sb.check_drained();

    $display("Covered %0d samples, %0d frames (%0d words), %0d register writes.",
             sb.samples_seen, sb.frames_predicted, sb.words_checked, sb.reg_writes);
    $display("Windows zero/one/full/saturated, thresholds 0..max, %0d long sink hold(s).",
             holds_done);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
